FILE: hdl/first_fit_free_list_allocator_defines.svh
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_DEFINES_SVH
// Assertion helpers shared by the checker.
`define FF_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define FF_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: hdl/ffa_pkg.sv
package ffa_pkg;
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned CntW = $clog2(TableDepth + 2);

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE = 2'd1;
  localparam logic [1:0] OP_TOTAL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MD_PASS,
    MD_SKIP,
    MD_DELAY
  } mode_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;
endpackage

FILE: hdl/ffa_cell.sv
module ffa_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  ffa_pkg::entry_t from_next,
  output ffa_pkg::entry_t q
);
  import ffa_pkg::*;
  entry_t q_r, q_nxt;
  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = from_next;
    end
  end
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end
  assign q = q_r;
endmodule

FILE: hdl/ffa_chain.sv
module ffa_chain (
  input  logic            clk,
  input  logic            rot,
  input  ffa_pkg::entry_t wr_data,
  output ffa_pkg::entry_t head
);
  import ffa_pkg::*;
  entry_t cell_q [TableDepth];
  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    entry_t nxt_in;
    if (i == TableDepth - 1) begin : g_last
      assign nxt_in = wr_data;
    end else begin : g_mid
      assign nxt_in = cell_q[i + 1];
    end
    ffa_cell u_cell (
      .clk(clk), .shift_en(rot), .from_next(nxt_in), .q(cell_q[i])
    );
  end
  assign head = cell_q[0];
endmodule

FILE: hdl/first_fit_free_list_allocator.sv
// Each item rotates the ring of TableDepth cells TableDepth + 2 times, two
// pipeline registers deep, and the result is registered in the cycle after
// the last rotation. An item is taken only while idle and with the result
// register free or being read in the same cycle, so a new item waits until
// the last one is done.
// Synchronous active-low reset empties the table and clears the counters.
module first_fit_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // operation[1:0], region_addr[33:2], region_size[65:34]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata  // granted_addr, status, free_total, entry_count
);
  import ffa_pkg::*;
  state_t st_r, st_nxt;
  mode_t mode_r, mode_nxt;
  logic [1:0] op_r;
  logic [31:0] addr_r, size_r, grant_r, grant_nxt, total_r, total_nxt;
  logic [31:0] lost_c_r, lost_b_r;
  logic [CntW-1:0] cnt_r, used_r, peak_r, nu_r, nu_nxt;
  logic done_r, done_nxt, stat_r, stat_nxt, lost_nxt, res_stat;
  entry_t d1_r, d2_r, d3_r, d2_nxt, d3_nxt, head, wr_data;
  logic rot, v1, v2, last_rot, acc;
  logic [79:0] res_r;
  logic res_v_r;

  ffa_chain u_chain (
    .clk(clk), .rot(rot), .wr_data(wr_data), .head(head)
  );

  assign in_tready = (st_r == ST_IDLE) && (!res_v_r || out_tready);
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = res_v_r;
  assign out_tdata = res_r;
  assign rot = (st_r == ST_SCAN);
  assign last_rot = (cnt_r == CntW'(TableDepth + 1));
  assign v1 = (cnt_r != '0) && (cnt_r <= used_r);
  assign v2 = (cnt_r >= CntW'(2)) && (cnt_r < used_r + CntW'(2));
  assign res_stat = (op_r == OP_ALLOC && !done_r) || stat_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (acc) st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_rot) st_nxt = ST_DONE;
      end
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // The entry two behind the head is normally written back to the tail, so
  // after TableDepth + 2 rotations every entry is back in its own cell.
  always_comb begin
    mode_nxt = mode_r;
    done_nxt = done_r;
    stat_nxt = stat_r;
    lost_nxt = 1'b0;
    grant_nxt = grant_r;
    total_nxt = total_r;
    nu_nxt = nu_r;
    d2_nxt = d1_r;
    d3_nxt = d2_r;
    case (mode_r)
      MD_SKIP: wr_data = d1_r;
      MD_DELAY: wr_data = d3_r;
      default: wr_data = d2_r;
    endcase
    if (op_r == OP_TOTAL && v2) total_nxt = total_r + d2_r.len;
    if (op_r == OP_ALLOC && !done_r && v2 && d2_r.len >= size_r) begin
      done_nxt = 1'b1;
      grant_nxt = d2_r.start;
      if (d2_r.len == size_r) begin
        wr_data = d1_r;
        mode_nxt = MD_SKIP;
        nu_nxt = used_r - CntW'(1);
      end else begin
        wr_data = '{start: d2_r.start + size_r, len: d2_r.len - size_r};
      end
    end
    if (op_r == OP_FREE && !done_r && cnt_r != '0 && (!v1 || d1_r.start > addr_r)) begin
      done_nxt = 1'b1;
      if (cnt_r >= CntW'(2) && d2_r.start + d2_r.len == addr_r) begin
        if (v1 && addr_r + size_r == d1_r.start) begin
          wr_data = '{start: d2_r.start, len: d2_r.len + size_r + d1_r.len};
          mode_nxt = MD_SKIP;
          nu_nxt = used_r - CntW'(1);
        end else begin
          wr_data = '{start: d2_r.start, len: d2_r.len + size_r};
        end
      end else if (v1 && addr_r + size_r == d1_r.start) begin
        d2_nxt = '{start: addr_r, len: d1_r.len + size_r};
      end else if (used_r < CntW'(TableDepth)) begin
        d3_nxt = '{start: addr_r, len: size_r};
        mode_nxt = MD_DELAY;
        nu_nxt = used_r + CntW'(1);
      end else begin
        stat_nxt = 1'b1;
        lost_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      used_r <= '0;
      peak_r <= '0;
      lost_c_r <= '0;
      lost_b_r <= '0;
      res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE) begin
        res_v_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        res_v_r <= 1'b0;
      end
      if (st_r == ST_SCAN && lost_nxt) begin
        lost_c_r <= lost_c_r + 32'd1;
        lost_b_r <= lost_b_r + size_r;
      end
      if (st_r == ST_DONE) begin
        used_r <= nu_r;
        if (peak_r < nu_r) peak_r <= nu_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r <= in_tdata[1:0];
      addr_r <= in_tdata[33:2];
      size_r <= in_tdata[65:34];
      cnt_r <= '0;
      mode_r <= MD_PASS;
      done_r <= 1'b0;
      stat_r <= 1'b0;
      grant_r <= '0;
      total_r <= '0;
      nu_r <= used_r;
    end else if (st_r == ST_SCAN) begin
      cnt_r <= cnt_r + CntW'(1);
      mode_r <= mode_nxt;
      done_r <= done_nxt;
      stat_r <= stat_nxt;
      grant_r <= grant_nxt;
      total_r <= total_nxt;
      nu_r <= nu_nxt;
      d1_r <= head;
      d2_r <= d2_nxt;
      d3_r <= d3_nxt;
    end
    if (st_r == ST_DONE) begin
      res_r <= {2'd0, nu_r, total_r, res_stat, grant_r};
    end
  end
endmodule

FILE: hdl/ffa_checker.sv
module ffa_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [79:0] out_tdata
);
  `include "first_fit_free_list_allocator_defines.svh"
  `FF_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `FF_ASSERT_NXT(a_data_hold, out_tvalid && !out_tready, $stable(out_tdata))
  `FF_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready)
endmodule

bind first_fit_free_list_allocator ffa_checker u_chk (.*);

FILE: tb/sv/testbench.sv
module testbench;
  import ffa_pkg::*;

  typedef struct packed {
    logic [12:0] count;
    logic [31:0] total;
    logic        status;
    logic [31:0] granted;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;

  reply_t      pending_replies[$];
  logic [31:0] free_start[$];
  logic [31:0] free_len[$];
  logic [31:0] owned_addr[$];
  logic [31:0] owned_size[$];
  int          errors;
  bit          quiet;
  int          stall_requests;
  int          stall_seen;
  int          stall_left;

  first_fit_free_list_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic reply_t predict_reply(logic [1:0] op, logic [31:0] addr,
                                           logic [31:0] size);
    reply_t r;
    int     pos;
    bit     done;
    r = '0;
    done = 0;
    if (op == OP_ALLOC) begin
      r.status = 1'b1;
      for (int k = 0; k < free_start.size() && !done; k++) begin
        if (free_len[k] >= size) begin
          r.granted = free_start[k];
          r.status = 1'b0;
          free_start[k] += size;
          free_len[k] -= size;
          if (free_len[k] == 0) begin
            free_start.delete(k);
            free_len.delete(k);
          end
          done = 1;
        end
      end
    end else if (op == OP_FREE) begin
      pos = 0;
      while (pos < free_start.size() && !(free_start[pos] > addr)) pos++;
      if (pos > 0 && free_start[pos - 1] + free_len[pos - 1] == addr) begin
        free_len[pos - 1] += size;
        if (pos < free_start.size() && addr + size == free_start[pos]) begin
          free_len[pos - 1] += free_len[pos];
          free_start.delete(pos);
          free_len.delete(pos);
        end
      end else if (pos < free_start.size() && addr + size == free_start[pos]) begin
        free_start[pos] = addr;
        free_len[pos] += size;
      end else if (free_start.size() < TableDepth) begin
        free_start.insert(pos, addr);
        free_len.insert(pos, size);
      end else begin
        r.status = 1'b1;
      end
    end else if (op == OP_TOTAL) begin
      foreach (free_len[k]) r.total += free_len[k];
    end
    r.count = 13'(free_start.size());
    return r;
  endfunction

  task automatic send_item(logic [1:0] op, logic [31:0] addr, logic [31:0] size);
    reply_t r;
    while (!quiet && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, size, addr, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = predict_reply(op, addr, size);
    if (op == OP_ALLOC && !r.status) begin
      owned_addr.push_back(r.granted);
      owned_size.push_back(size);
    end
    pending_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      stall_seen <= 0;
    end else if (stall_requests != stall_seen) begin
      stall_seen <= stall_requests;
      stall_left <= 20000;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || $urandom_range(99) >= 34;
    end
  end

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[77:0];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (got.granted !== want.granted) begin
          $display("%0t: granted_addr expected %h actual %h", $time, want.granted,
                   got.granted);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, got.status);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: free_total expected %h actual %h", $time, want.total, got.total);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   got.count);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table;
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_TOTAL, 32'd0, 32'd0);
    send_item(OP_ALLOC, 32'd0, 32'd1);
    send_item(OP_ALLOC, 32'd0, 32'd0);
  endtask

  task automatic test_extremes;
    send_item(OP_FREE, 32'd0, 32'h100);
    send_item(OP_ALLOC, 32'd0, 32'd0);
    send_item(OP_FREE, 32'h5000, 32'd0);
    send_item(OP_FREE, 32'hFFFF_FF00, 32'h100);
    send_item(OP_ALLOC, 32'd0, 32'h100);
    send_item(OP_ALLOC, 32'd0, 32'd0);
    send_item(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_TOTAL, 32'd0, 32'd0);
    send_item(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    send_item(2'd3, 32'd0, 32'd0);
  endtask

  task automatic test_coalescing;
    send_item(OP_FREE, 32'h1000, 32'h100);
    send_item(OP_FREE, 32'h1200, 32'h100);
    send_item(OP_FREE, 32'h1100, 32'h100);
    send_item(OP_FREE, 32'h0F00, 32'h100);
    send_item(OP_FREE, 32'h1300, 32'h80);
    send_item(OP_FREE, 32'h2000, 32'h40);
    send_item(OP_ALLOC, 32'd0, 32'h40);
    send_item(OP_ALLOC, 32'd0, 32'h500);
    send_item(OP_TOTAL, 32'd0, 32'd0);
  endtask

  task automatic random_op;
    int          pick;
    int          idx;
    logic [31:0] a;
    logic [31:0] s;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_item(OP_ALLOC, $urandom, $urandom_range(256, 1));
    end else if (pick < 75 && owned_addr.size() > 0) begin
      idx = $urandom_range(owned_addr.size() - 1);
      a = owned_addr[idx];
      s = owned_size[idx];
      owned_addr.delete(idx);
      owned_size.delete(idx);
      send_item(OP_FREE, a, s);
    end else if (pick < 85) begin
      send_item(OP_FREE, $urandom, ($urandom_range(1) != 0) ? $urandom : $urandom_range(4096));
    end else if (pick < 95) begin
      send_item(OP_TOTAL, $urandom, $urandom);
    end else begin
      send_item(2'd3, $urandom, $urandom);
    end
  endtask

  task automatic test_random;
    send_item(OP_FREE, 32'h10_0000, 32'h1_0000);
    send_item(OP_FREE, 32'h40_0000, 32'h800);
    for (int n = 0; n < 108; n++) begin
      quiet = (n >= 40 && n < 60);
      random_op();
    end
    quiet = 0;
  endtask

  task automatic test_backpressure;
    stall_requests++;
    for (int n = 0; n < 6; n++) random_op();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    errors = 0;
    quiet = 0;
    stall_requests = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_extremes();
    test_coalescing();
    test_backpressure();
    test_random();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (2 * TableDepth + 20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #64000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hdl
hdl/ffa_pkg.sv
hdl/ffa_cell.sv
hdl/ffa_chain.sv
hdl/first_fit_free_list_allocator.sv
hdl/ffa_checker.sv
tb/sv/testbench.sv
